@@ rtl/core/lsnq_pkg.sv @@
// Shared constants and types for the line sensor normalize/quantize core.
// No dependencies; imported by the core and by its port checker.
package lsnq_pkg;

  localparam int MAX_SENSORS_DEF = 9;
  localparam int SAMPLE_BITS_DEF = 10;

  localparam int CMD_W   = 2;
  localparam int CH_W    = 4;
  localparam int CNT_W   = 4;
  localparam int LEVEL_W = 4;
  localparam int OUT_DW  = 8;

  typedef logic [CMD_W-1:0]   cmd_t;
  typedef logic [LEVEL_W-1:0] level_t;
  typedef logic [CH_W-1:0]    chan_t;

  localparam cmd_t CMD_SAMPLE = 2'd0;
  localparam cmd_t CMD_DARK   = 2'd1;
  localparam cmd_t CMD_LIGHT  = 2'd2;

  localparam logic [CNT_W-1:0] ACTIVE_COUNT_RESET = 4'd9;
  localparam level_t           LEVEL_MAX          = 4'd9;
  localparam int               LEVEL_STEP         = 100;

endpackage

@@ rtl/core/line_sensor_normalize_quantize_core.sv @@
// Line sensor normalize/quantize core: calibration tables, scan pointer and
// a bit-serial divider. Depends on lsnq_pkg.
// Sequence: a sample word is accepted, then a setup step, the divider steps and
// an output load step that waits while out_* is stalled; the result then shows on out_*.
// A new sample is taken only after the previous result is loaded; the radix-2 divider
// gives one quotient bit per cycle. A calibration word is taken while idle and gives no result.
// Reset (rst_n low, synchronous): tables and scan pointer clear to zero, active
// sensor count returns to 9, no result pending.
module line_sensor_normalize_quantize_core #(
  parameter int MAX_SENSORS = lsnq_pkg::MAX_SENSORS_DEF,
  parameter int SAMPLE_BITS = lsnq_pkg::SAMPLE_BITS_DEF,
  parameter int IN_DW       = ((SAMPLE_BITS + lsnq_pkg::CH_W + 7) / 8) * 8
) (
  input  logic                           clk,
  input  logic                           rst_n,
  // configuration: active sensor count
  input  logic                           cfg_wr_en,
  input  logic [lsnq_pkg::CNT_W-1:0]     cfg_wr_data,
  // input stream
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [IN_DW-1:0]               in_tdata,  // raw_sample, cal_channel, zero fill
  input  logic [lsnq_pkg::CMD_W-1:0]     in_tuser,  // cmd
  // result stream
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [lsnq_pkg::OUT_DW-1:0]    out_tdata, // level, channel
  output logic                           out_tlast, // scan_done
  output logic                           out_tuser  // zero_span
);
  import lsnq_pkg::*;

  localparam int IDX_W = (MAX_SENSORS > 1) ? $clog2(MAX_SENSORS) : 1;
  // remainder/divisor width: product needs 2*S bits, divisor*100*16 needs S+11
  localparam int RW = (2 * SAMPLE_BITS > SAMPLE_BITS + 11) ? 2 * SAMPLE_BITS
                                                           : SAMPLE_BITS + 11;

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_SETUP  = 2'd1;
  localparam logic [1:0] ST_DIV    = 2'd2;
  localparam logic [1:0] ST_FINISH = 2'd3;

  localparam logic [2:0] DIV_FIRST = 3'd4;

  // ---------------------------------------------------------------------------
  // Input word decode
  // ---------------------------------------------------------------------------
  cmd_t                   in_cmd;
  logic [SAMPLE_BITS-1:0] in_raw;
  chan_t                  in_cal_ch;
  logic                   in_acc;
  logic                   cal_wr_ok;

  assign in_cmd    = cmd_t'(in_tuser);
  assign in_raw    = in_tdata[SAMPLE_BITS-1:0];
  assign in_cal_ch = in_tdata[SAMPLE_BITS+CH_W-1:SAMPLE_BITS];
  assign in_acc    = in_tvalid && in_tready;
  // drop calibration writes to channels that do not exist
  assign cal_wr_ok = ({1'b0, in_cal_ch} < (CH_W+1)'(MAX_SENSORS));

  // ---------------------------------------------------------------------------
  // Control state
  // ---------------------------------------------------------------------------
  logic [1:0]       state_r, state_nxt;
  logic [CNT_W-1:0] active_cnt_r;
  chan_t            ptr_r;
  logic [2:0]       cnt_r;

  assign in_tready = (state_r == ST_IDLE);

  // Effective count: zero acts as one, large values clamp to the bank size.
  logic [CH_W:0] eff_cnt;
  logic [CH_W:0] next_ch;
  chan_t         ch_cur;
  logic          scan_end;

  always_comb begin
    if (active_cnt_r == '0) begin
      eff_cnt = (CH_W+1)'(1);
    end else if ({1'b0, active_cnt_r} > (CH_W+1)'(MAX_SENSORS)) begin
      eff_cnt = (CH_W+1)'(MAX_SENSORS);
    end else begin
      eff_cnt = {1'b0, active_cnt_r};
    end
  end

  // A stale pointer beyond the bank restarts at channel zero.
  assign ch_cur   = ({1'b0, ptr_r} >= (CH_W+1)'(MAX_SENSORS)) ? '0 : ptr_r;
  assign next_ch  = {1'b0, ch_cur} + (CH_W+1)'(1);
  assign scan_end = (next_ch >= eff_cnt);

  // ---------------------------------------------------------------------------
  // Calibration tables: written by calibration words, read once per sample
  // ---------------------------------------------------------------------------
  logic [SAMPLE_BITS-1:0] dark_table_r  [MAX_SENSORS];
  logic [SAMPLE_BITS-1:0] light_table_r [MAX_SENSORS];
  logic [SAMPLE_BITS-1:0] dark_rd_r, light_rd_r, raw_r;
  chan_t                  ch_r;
  logic                   done_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < MAX_SENSORS; i++) begin
        dark_table_r[i]  <= '0;
        light_table_r[i] <= '0;
      end
    end else if (in_acc && cal_wr_ok) begin
      if (in_cmd == CMD_DARK) begin
        dark_table_r[in_cal_ch[IDX_W-1:0]] <= in_raw;
      end
      if (in_cmd == CMD_LIGHT) begin
        light_table_r[in_cal_ch[IDX_W-1:0]] <= in_raw;
      end
    end
  end

  // Capture the sample and its calibration pair at acceptance.
  always_ff @(posedge clk) begin
    if (in_acc && in_cmd == CMD_SAMPLE) begin
      raw_r      <= in_raw;
      ch_r       <= ch_cur;
      done_r     <= scan_end;
      dark_rd_r  <= dark_table_r[ch_cur[IDX_W-1:0]];
      light_rd_r <= light_table_r[ch_cur[IDX_W-1:0]];
    end
  end

  // ---------------------------------------------------------------------------
  // Setup: magnitudes, sign check, dividend and scaled divisor
  // level = min(floor(num * FULL_SCALE / (den * LEVEL_STEP)), LEVEL_MAX)
  // ---------------------------------------------------------------------------
  logic                   num_neg, den_neg;
  logic [SAMPLE_BITS-1:0] num_mag, den_mag;
  logic [RW-1:0]          num_ext, den_ext, prod, div_init;

  assign num_neg  = (raw_r < dark_rd_r);
  assign den_neg  = (light_rd_r < dark_rd_r);
  assign num_mag  = num_neg ? (dark_rd_r - raw_r) : (raw_r - dark_rd_r);
  assign den_mag  = den_neg ? (dark_rd_r - light_rd_r) : (light_rd_r - dark_rd_r);
  assign num_ext  = RW'(num_mag);
  assign den_ext  = RW'(den_mag);
  // num * (2^S - 1) as a shift and subtract
  assign prod     = (num_ext << SAMPLE_BITS) - num_ext;
  // divisor * 16: the first step only checks for saturation
  assign div_init = (den_ext * RW'(LEVEL_STEP)) << 4;

  logic [RW-1:0]      rem_r, rem_nxt;
  logic [RW-1:0]      div_r, div_nxt;
  level_t             quo_r, quo_nxt;
  logic               sat_r, sat_nxt;
  logic               zero_r, force0_r;
  logic [2:0]         cnt_nxt;
  logic               rem_ge;

  assign rem_ge = (rem_r >= div_r);

  // ---------------------------------------------------------------------------
  // Sequencer and bit-serial divider
  // ---------------------------------------------------------------------------
  level_t level_fin;
  logic   out_load;

  assign level_fin = (zero_r || force0_r) ? '0 :
                     (sat_r || quo_r > LEVEL_MAX) ? LEVEL_MAX : quo_r;
  assign out_load  = (state_r == ST_FINISH) && (!out_tvalid || out_tready);

  always_comb begin
    state_nxt = state_r;
    rem_nxt   = rem_r;
    div_nxt   = div_r;
    quo_nxt   = quo_r;
    sat_nxt   = sat_r;
    cnt_nxt   = cnt_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc && in_cmd == CMD_SAMPLE) begin
          state_nxt = ST_SETUP;
        end
      end
      ST_SETUP: begin
        rem_nxt   = prod;
        div_nxt   = div_init;
        quo_nxt   = '0;
        sat_nxt   = 1'b0;
        cnt_nxt   = DIV_FIRST;
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        if (cnt_r == DIV_FIRST) begin
          // quotient of 16 or more: clamp without further steps mattering
          sat_nxt = rem_ge;
        end else begin
          quo_nxt = {quo_r[LEVEL_W-2:0], rem_ge};
          if (rem_ge) begin
            rem_nxt = rem_r - div_r;
          end
        end
        div_nxt = div_r >> 1;
        cnt_nxt = cnt_r - 3'd1;
        if (cnt_r == '0) begin
          state_nxt = ST_FINISH;
        end
      end
      ST_FINISH: begin
        // hold until the output register is free
        if (out_load) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      ptr_r        <= '0;
      active_cnt_r <= ACTIVE_COUNT_RESET;
      cnt_r        <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      if (cfg_wr_en) begin
        active_cnt_r <= cfg_wr_data;
      end
      // advance the scan pointer at sample acceptance
      if (in_acc && in_cmd == CMD_SAMPLE) begin
        ptr_r <= scan_end ? '0 : next_ch[CH_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    div_r <= div_nxt;
    quo_r <= quo_nxt;
    sat_r <= sat_nxt;
    if (state_r == ST_SETUP) begin
      zero_r   <= (den_mag == '0);
      force0_r <= (num_mag == '0) || (num_neg != den_neg);
    end
  end

  // ---------------------------------------------------------------------------
  // Output register
  // ---------------------------------------------------------------------------
  logic   out_valid_r;
  level_t out_level_r;
  chan_t  out_ch_r;
  logic   out_last_r, out_zero_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_level_r <= level_fin;
      out_ch_r    <= ch_r;
      out_last_r  <= done_r;
      out_zero_r  <= zero_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_ch_r, out_level_r};
  assign out_tlast  = out_last_r;
  assign out_tuser  = out_zero_r;

endmodule

@@ rtl/core/lsnq_checker.sv @@
// Port-level checker for the line sensor normalize/quantize core, bound to it.
// Depends on lsnq_pkg and on the core's port list.
module lsnq_checker #(
  parameter int MAX_SENSORS = lsnq_pkg::MAX_SENSORS_DEF,
  parameter int SAMPLE_BITS = lsnq_pkg::SAMPLE_BITS_DEF
) (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_tvalid,
  input logic                        in_tready,
  input logic [lsnq_pkg::CMD_W-1:0]  in_tuser,  // cmd
  input logic                        out_tvalid,
  input logic                        out_tready,
  input logic [lsnq_pkg::OUT_DW-1:0] out_tdata, // level, channel
  input logic                        out_tuser  // zero_span
);
  import lsnq_pkg::*;

  // level never exceeds the top step
  a_level_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[LEVEL_W-1:0] <= LEVEL_MAX)
    else $error("level above maximum");

  // empty span forces level zero
  a_zero_span_level: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser) |-> out_tdata[LEVEL_W-1:0] == '0)
    else $error("zero span with nonzero level");

  // reported channel lies inside the bank
  a_channel_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> {1'b0, out_tdata[OUT_DW-1:LEVEL_W]} < (CH_W+1)'(MAX_SENSORS))
    else $error("channel outside sensor bank");

  // a sample word occupies the divider: no word taken next cycle
  a_busy_after_sample: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready && in_tuser == CMD_SAMPLE) |=> !in_tready)
    else $error("input ready while sample in progress");

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> (out_tvalid && $stable(out_tdata)))
    else $error("stalled result changed");

endmodule

bind line_sensor_normalize_quantize_core lsnq_checker #(
  .MAX_SENSORS(MAX_SENSORS),
  .SAMPLE_BITS(SAMPLE_BITS)
) u_lsnq_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_tvalid (in_tvalid),
  .in_tready (in_tready),
  .in_tuser  (in_tuser),
  .out_tvalid(out_tvalid),
  .out_tready(out_tready),
  .out_tdata (out_tdata),
  .out_tuser (out_tuser)
);

@@ tb/tb.sv @@
// Testbench for line_sensor_normalize_quantize_core: directed and random words
// on the input stream, every result checked against an in-bench level predictor.
// Depends on lsnq_pkg and the core itself.
module tb;
  import lsnq_pkg::*;

  typedef logic [SAMPLE_BITS_DEF-1:0] raw_t;

  // Result word as the predictor sees it, one field per output field.
  typedef struct packed {
    level_t level;
    chan_t  channel;
    logic   scan_done;
    logic   zero_span;
  } level_word_t;

  localparam cmd_t CMD_UNUSED  = 2'd3;       // reserved command, ignored by the core
  localparam int   FULL_SCALE  = 1023;       // normalized full scale
  localparam int   IN_W        = ((SAMPLE_BITS_DEF + CH_W + 7) / 8) * 8;
  localparam int   HOLD_OFF    = 16;         // idle cycles after the last result
  localparam int   CYCLE_LIMIT = 1000000;    // watchdog limit
  localparam int   PHASES      = 16;         // random phases
  localparam int   PHASE_WORDS = 90;         // effective words per random phase

  logic             clk;
  logic             rst_n;
  logic             cfg_wr_en;
  logic [CNT_W-1:0] cfg_wr_data;
  logic             in_tvalid;
  logic             in_tready;
  logic [IN_W-1:0]  in_tdata;   // raw_sample, cal_channel, zero fill
  cmd_t             in_tuser;   // cmd
  logic             out_tvalid;
  logic             out_tready;
  logic [OUT_DW-1:0] out_tdata; // level, channel
  logic             out_tlast;  // scan_done
  logic             out_tuser;  // zero_span

  line_sensor_normalize_quantize_core u_top (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tlast   (out_tlast),
    .out_tuser   (out_tuser)
  );

  // Predictor state: its own copy of the calibration tables, pointer and count.
  raw_t             dark_cal  [MAX_SENSORS_DEF];
  raw_t             light_cal [MAX_SENSORS_DEF];
  chan_t            scan_ptr;
  logic [CNT_W-1:0] active_count;

  // Levels still owed by the core, oldest first.
  level_word_t pending_levels[$];

  int  mismatches = 0;
  int  words_sent;
  int  levels_checked = 0;
  int  counts_written;
  int  cycle_count = 0;
  bit  quiet;          // suppress idling on both sides
  int  hold_req_len;   // long receiver hold-off, picked up by the ready process
  int  hold_req_id;

  // Clock: period of 2 time units.
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Watchdog: count cycles and give up at the limit.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
  end

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("Timeout after %0d cycles, %0d levels still owed", cycle_count,
             pending_levels.size());
    $display("Verification failed");
    $finish;
  end

  // Print one line per mismatch and count every one.
  task automatic report_mismatch(input string what);
    mismatches++;
    $display("[%0t] mismatch: %s", $time, what);
  endtask

  // Gap length for either side: mostly none, some short, a few long.
  function automatic int pick_gap();
    int r;
    if (quiet) return 0;
    r = $urandom_range(99);
    if (r < 60) return 0;
    if (r < 88) return $urandom_range(3, 1);
    if (r < 98) return $urandom_range(12, 4);
    return $urandom_range(60, 20);
  endfunction

  // Quantized level for one sample: signed span, exact truncating division,
  // then steps of 100 clamped to the top level. An empty span flags zero_span.
  function automatic level_t quantize_level(input raw_t raw, input raw_t dark,
                                            input raw_t light, output logic empty_span);
    int num;
    int den;
    int q;
    empty_span = 1'b0;
    num = int'(raw) - int'(dark);
    den = int'(light) - int'(dark);
    if (den == 0) begin
      empty_span = 1'b1;
      return '0;
    end
    // Zero or negative normalized value reads as the bottom level.
    if (num == 0 || ((num < 0) != (den < 0))) return '0;
    if (num < 0) begin
      num = -num;
      den = -den;
    end
    q = (num * FULL_SCALE) / den / LEVEL_STEP;
    if (q > int'(LEVEL_MAX)) q = int'(LEVEL_MAX);
    return level_t'(q);
  endfunction

  // Advance the predictor by one accepted word; queue the level it causes.
  function automatic void apply_word(input cmd_t cmd, input raw_t raw, input chan_t cch);
    level_word_t lw;
    int          ch;
    int          eff;
    int          nxt;
    case (cmd)
      CMD_DARK: begin
        // Channels past the table are dropped; past the active count still stored.
        if (cch < MAX_SENSORS_DEF) dark_cal[cch] = raw;
      end
      CMD_LIGHT: begin
        if (cch < MAX_SENSORS_DEF) light_cal[cch] = raw;
      end
      CMD_SAMPLE: begin
        ch  = (scan_ptr >= MAX_SENSORS_DEF) ? 0 : int'(scan_ptr);
        eff = (active_count == 0) ? 1 :
              ((active_count > MAX_SENSORS_DEF) ? MAX_SENSORS_DEF : int'(active_count));
        lw.level   = quantize_level(raw, dark_cal[ch], light_cal[ch], lw.zero_span);
        lw.channel = chan_t'(ch);
        // Wrap when the pointer reaches or passes the count, even a lowered one.
        nxt          = ch + 1;
        lw.scan_done = (nxt >= eff);
        if (lw.scan_done) nxt = 0;
        scan_ptr = chan_t'(nxt);
        pending_levels.push_back(lw);
      end
      default: ;  // unused command: no state change, no level
    endcase
  endfunction

  // Offer one word after a random gap; return at the edge that accepts it,
  // with tvalid still high so a back-to-back word needs no extra assignment.
  task automatic send_word(input cmd_t cmd, input raw_t raw, input chan_t cch);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= cmd;
    in_tdata  <= {{(IN_W - SAMPLE_BITS_DEF - CH_W){1'b0}}, cch, raw};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    apply_word(cmd, raw, cch);
    words_sent++;
  endtask

  // Stop offering, wait until every owed level has come, then let the core settle.
  task automatic drain_results();
    in_tvalid <= 1'b0;
    while (pending_levels.size() != 0) @(posedge clk);
    repeat (HOLD_OFF) @(posedge clk);
  endtask

  // Write the active count while the core is idle.
  task automatic write_count(input logic [CNT_W-1:0] value);
    drain_results();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    active_count = value;
    cfg_wr_en <= 1'b0;
    counts_written++;
  endtask

  // Receiver: random stalls, plus a long hold-off whenever a test asks for one.
  initial begin : drive_ready
    int stall_left;
    int seen_id;
    stall_left = 0;
    seen_id    = 0;
    out_tready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req_id != seen_id) begin
        seen_id    = hold_req_id;
        stall_left = hold_req_len;
      end
      if (stall_left == 0 && !quiet && $urandom_range(99) < 25) stall_left = pick_gap();
      out_tready <= (stall_left == 0);
      if (stall_left > 0) stall_left--;
    end
  end

  // Compare each accepted result word, field by field, with the oldest level owed.
  always @(posedge clk) begin : check_results
    level_word_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_levels.size() == 0) begin
        report_mismatch($sformatf("unexpected result word data=%h last=%b user=%b",
                                  out_tdata, out_tlast, out_tuser));
      end else begin
        want = pending_levels.pop_front();
        if (out_tdata[LEVEL_W-1:0] != want.level)
          report_mismatch($sformatf("level got %0d want %0d (channel %0d)",
                                    out_tdata[LEVEL_W-1:0], want.level, want.channel));
        if (out_tdata[LEVEL_W +: CH_W] != want.channel)
          report_mismatch($sformatf("channel got %0d want %0d",
                                    out_tdata[LEVEL_W +: CH_W], want.channel));
        if (out_tlast != want.scan_done)
          report_mismatch($sformatf("scan_done got %b want %b (channel %0d)",
                                    out_tlast, want.scan_done, want.channel));
        if (out_tuser != want.zero_span)
          report_mismatch($sformatf("zero_span got %b want %b (channel %0d)",
                                    out_tuser, want.zero_span, want.channel));
        levels_checked++;
      end
    end
  end

  // Fresh tables read as an empty span on every channel.
  task automatic test_reset_state();
    repeat (3) send_word(CMD_SAMPLE, raw_t'($urandom_range(1023)), chan_t'(0));
  endtask

  // Single-channel scan: span extremes, clamping, negative and inverted spans,
  // empty span and the words the core drops.
  task automatic test_calibration_corners();
    write_count(4'd1);
    send_word(CMD_DARK,   10'd0,    4'd0);
    send_word(CMD_LIGHT,  10'd1023, 4'd0);
    send_word(CMD_SAMPLE, 10'd0,    4'd0);
    send_word(CMD_SAMPLE, 10'd1023, 4'd0);
    send_word(CMD_SAMPLE, 10'd99,   4'd0);
    send_word(CMD_SAMPLE, 10'd100,  4'd0);
    send_word(CMD_SAMPLE, 10'd511,  4'd0);
    send_word(CMD_SAMPLE, 10'd1000, 4'd0);   // clamps to the top level
    send_word(CMD_DARK,   10'd600,  4'd0);
    send_word(CMD_SAMPLE, 10'd100,  4'd0);   // below dark: bottom level
    send_word(CMD_LIGHT,  10'd200,  4'd0);   // light under dark: inverted span
    send_word(CMD_SAMPLE, 10'd100,  4'd0);
    send_word(CMD_SAMPLE, 10'd700,  4'd0);
    send_word(CMD_LIGHT,  10'd600,  4'd0);   // light equals dark: empty span
    send_word(CMD_SAMPLE, 10'd1023, 4'd0);
    send_word(CMD_UNUSED, 10'd1023, 4'd15);  // dropped
    send_word(CMD_DARK,   10'd1023, 4'd9);   // channel past the table: dropped
    send_word(CMD_LIGHT,  10'd1023, 4'd15);
    send_word(CMD_DARK,   10'd5,    4'd8);   // past the active count: still stored
    send_word(CMD_LIGHT,  10'd1023, 4'd8);
    send_word(CMD_SAMPLE, 10'd300,  4'd0);
  endtask

  // Count changes mid-scan, and the out-of-range count values.
  task automatic test_count_changes();
    write_count(4'd9);
    repeat (5) send_word(CMD_SAMPLE, raw_t'($urandom_range(1023)), chan_t'(0));
    write_count(4'd3);   // pointer sits past the new count: wraps with scan_done
    send_word(CMD_SAMPLE, raw_t'($urandom_range(1023)), chan_t'(0));
    write_count(4'd0);   // acts as one channel
    repeat (2) send_word(CMD_SAMPLE, raw_t'($urandom_range(1023)), chan_t'(0));
    write_count(4'd15);  // acts as the full table
    repeat (10) send_word(CMD_SAMPLE, raw_t'($urandom_range(1023)), chan_t'(0));
  endtask

  // Hold the receiver off for a long stretch while the sender keeps offering
  // back to back, so the core fills up and stalls its input.
  task automatic test_backpressure();
    write_count(4'd9);
    quiet        = 1'b1;
    hold_req_len = 400;
    hold_req_id++;
    repeat (24) send_word(CMD_SAMPLE, raw_t'($urandom_range(1023)), chan_t'(0));
    quiet = 1'b0;
    drain_results();
  endtask

  // Random phases: a fresh count each phase, mostly calibrations and samples
  // with random content, some noise the core ignores.
  task automatic test_random_traffic();
    int   phase;
    int   done_words;
    int   r;
    cmd_t cmd;
    raw_t raw;
    chan_t cch;
    for (phase = 0; phase < PHASES; phase++) begin
      if (phase == 0) write_count(4'd9);
      else if (phase == 1) write_count(4'd1);
      else if ($urandom_range(9) < 7) write_count(4'($urandom_range(9, 1)));
      else write_count(4'($urandom_range(15)));
      quiet      = ($urandom_range(3) == 0);
      done_words = 0;
      while (done_words < PHASE_WORDS) begin
        r = $urandom_range(99);
        if (r < 68) begin
          cmd = CMD_SAMPLE;
          raw = raw_t'($urandom_range(1023));
          cch = chan_t'($urandom_range(15));
          done_words++;
        end else if (r < 90) begin
          cmd = ($urandom_range(1) == 0) ? CMD_DARK : CMD_LIGHT;
          cch = chan_t'($urandom_range(MAX_SENSORS_DEF - 1));
          // Hold dark low and light high most of the time; sometimes anything.
          if ($urandom_range(99) < 15) raw = raw_t'($urandom_range(1023));
          else if (cmd == CMD_DARK) raw = raw_t'($urandom_range(400));
          else raw = raw_t'($urandom_range(1023, 600));
          done_words++;
        end else begin
          // Noise: unused command or a channel past the table.
          raw = raw_t'($urandom_range(1023));
          if ($urandom_range(1) == 0) begin
            cmd = CMD_UNUSED;
            cch = chan_t'($urandom_range(15));
          end else begin
            cmd = ($urandom_range(1) == 0) ? CMD_DARK : CMD_LIGHT;
            cch = chan_t'($urandom_range(15, MAX_SENSORS_DEF));
          end
        end
        send_word(cmd, raw, cch);
        // Now and then pause the sender until everything owed has arrived.
        if (done_words == PHASE_WORDS / 2 && $urandom_range(3) == 0) begin
          drain_results();
          done_words++;
        end
      end
    end
  endtask

  initial begin
    int i;
    for (i = 0; i < MAX_SENSORS_DEF; i++) begin
      dark_cal[i]  = '0;
      light_cal[i] = '0;
    end
    scan_ptr       = '0;
    active_count   = ACTIVE_COUNT_RESET;
    words_sent     = 0;
    counts_written = 0;
    quiet          = 1'b0;
    hold_req_len   = 0;
    hold_req_id    = 0;
    rst_n       <= 1'b0;
    cfg_wr_en   <= 1'b0;
    cfg_wr_data <= '0;
    in_tvalid   <= 1'b0;
    in_tdata    <= '0;
    in_tuser    <= CMD_SAMPLE;

    // Hold reset, then release it once for the whole run.
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_state();
    test_calibration_corners();
    test_count_changes();
    test_backpressure();
    test_random_traffic();
    drain_results();

    $display("Run covered %0d input words, %0d result words checked, %0d count writes",
             words_sent, levels_checked, counts_written);
    $display("including span corners, count wrap, back-pressure and random phases");
    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("Verification failed");
    end
    $finish;
  end

endmodule
